>>> src/fhcc_pkg.sv
// Shared constants, types and CRC byte-update functions for the frame
// header/body CRC checker. No dependencies.
package fhcc_pkg;

   localparam int MAX_FRAME   = 4096;
   localparam int COUNT_W     = 13;
   localparam int COUNT_LIMIT = (MAX_FRAME < 8191) ? MAX_FRAME : 8191;

   localparam int HLEN_W  = 6;
   localparam int SEED8_W = 8;
   localparam int SEED16_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LEN      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_CRC_SEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_CRC_SEED  = 2'd2;

   localparam logic [HLEN_W-1:0]   HEADER_LEN_RST = 6'd5;
   localparam logic [SEED8_W-1:0]  HDR_SEED_RST   = 8'hff;
   localparam logic [SEED16_W-1:0] FRM_SEED_RST   = 16'hffff;

   localparam logic [7:0]  CRC8_POLY_REFL  = 8'h8c;
   localparam logic [15:0] CRC16_POLY_REFL = 16'h8408;

   // one classified byte handed from the front end to the CRC engine
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       first;      // first byte of frame: load seeds
      logic       hdr_upd;    // fold byte into CRC-8
      logic       hdr_cmp;    // byte is the header check byte
      logic       ge2;        // position >= 2: fold oldest held byte into CRC-16
   } item_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> src/fhcc_req_if.sv
// Byte input channel: valid/ready handshake with frame byte and last marker.
// Depends on nothing.
interface fhcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/fhcc_rsp_if.sv
// Result channel: valid/ready handshake with match flags and computed CRCs.
// Depends on nothing.
interface fhcc_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_ok;
   logic        frame_ok;
   logic [7:0]  header_crc;
   logic [15:0] frame_crc;

   modport source (output valid, output header_ok, output frame_ok,
                   output header_crc, output frame_crc, input ready);
   modport sink   (input valid, input header_ok, input frame_ok,
                   input header_crc, input frame_crc, output ready);
endinterface

>>> src/fhcc_front.sv
// Front end: accepts bytes, tracks position in frame, classifies each byte.
// Depends on fhcc_pkg, fhcc_req_if.
module fhcc_front (
   input  logic                           clock,
   input  logic                           reset,
   fhcc_req_if.sink                       req,
   input  logic [fhcc_pkg::HLEN_W-1:0]    header_len,
   input  logic                           q_full,
   output logic                           q_push,
   output fhcc_pkg::item_type             q_item
);

   logic [fhcc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [fhcc_pkg::COUNT_W:0]   pos_p1;
   logic [fhcc_pkg::COUNT_W:0]   hlen_x;
   logic                         sat;
   logic                         hdr_upd;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   assign sat    = (count_ff == fhcc_pkg::COUNT_W'(fhcc_pkg::COUNT_LIMIT));
   assign pos_p1 = {1'b0, count_ff} + (fhcc_pkg::COUNT_W+1)'(1);
   assign hlen_x = (fhcc_pkg::COUNT_W+1)'(header_len);
   assign hdr_upd = !sat && (header_len != '0) && (pos_p1 < hlen_x);

   always_comb begin
      q_item.data_byte = req.data_byte;
      q_item.last_byte = req.last_byte;
      q_item.first     = (count_ff == '0);
      q_item.hdr_upd   = hdr_upd;
      q_item.hdr_cmp   = !sat && !hdr_upd && (header_len >= fhcc_pkg::HLEN_W'(3))
                         && (pos_p1 == hlen_x);
      q_item.ge2       = (count_ff >= fhcc_pkg::COUNT_W'(2));
   end

   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         if (req.last_byte)
            count_in = '0;
         else if (!sat)
            count_in = count_ff + fhcc_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> src/fhcc_queue.sv
// Two-entry FIFO of classified bytes between front end and CRC engine.
// Depends on fhcc_pkg.
module fhcc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fhcc_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output fhcc_pkg::item_type head
);

   fhcc_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> src/fhcc_back.sv
// CRC engine: byte-wise CRC-8 / CRC-16 update, header compare, two-byte
// hold line and registered result output. Depends on fhcc_pkg, fhcc_rsp_if.
module fhcc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  fhcc_pkg::item_type               q_item,
   output logic                             q_pop,
   input  logic [fhcc_pkg::SEED8_W-1:0]     hdr_seed,
   input  logic [fhcc_pkg::SEED16_W-1:0]    frm_seed,
   fhcc_rsp_if.source                       rsp
);

   logic [7:0]  hcrc_ff, hcrc_in, hcrc_cur;
   logic        match_ff, match_in, match_cur;
   logic [15:0] fcrc_ff, fcrc_in, fcrc_cur;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;

   logic        out_vld_ff, out_vld_in;
   logic        hok_ff, fok_ff;
   logic [7:0]  hcrc_out_ff;
   logic [15:0] fcrc_out_ff;
   logic        emit;

   // non-last bytes never touch the output register, so they flow freely
   assign q_pop = q_valid && (!q_item.last_byte || !out_vld_ff || rsp.ready);
   assign emit  = q_pop && q_item.last_byte;

   always_comb begin
      hcrc_cur  = q_item.first ? hdr_seed : hcrc_ff;
      fcrc_cur  = q_item.first ? frm_seed : fcrc_ff;
      match_cur = q_item.first ? 1'b0 : match_ff;

      hcrc_in  = q_item.hdr_upd ? fhcc_pkg::crc8_byte(hcrc_cur, q_item.data_byte) : hcrc_cur;
      match_in = q_item.hdr_cmp ? (hcrc_cur == q_item.data_byte) : match_cur;
      fcrc_in  = q_item.ge2 ? fhcc_pkg::crc16_byte(fcrc_cur, held0_ff) : fcrc_cur;
      held0_in = held1_ff;
      held1_in = q_item.data_byte;
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (emit)
         out_vld_in = 1'b1;
      else if (rsp.ready)
         out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         hcrc_ff  <= hcrc_in;
         match_ff <= match_in;
         fcrc_ff  <= fcrc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
      if (emit) begin
         hok_ff      <= match_in;
         fok_ff      <= q_item.ge2 && (fcrc_in == {held1_in, held0_in});
         hcrc_out_ff <= hcrc_in;
         fcrc_out_ff <= fcrc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.header_ok  = hok_ff;
   assign rsp.frame_ok   = fok_ff;
   assign rsp.header_crc = hcrc_out_ff;
   assign rsp.frame_crc  = fcrc_out_ff;

endmodule

>>> src/frame_header_and_body_crc_checker_core.sv
// Result path: a frame's last byte passes a queue slot, then the CRC engine's output
// register; the result comes later if bytes wait ahead of it.
// Throughput: one byte per cycle while the queue has room, held by the two-entry queue
// feeding the CRC-8/CRC-16 byte update. A stalled result only blocks the engine when the next
// last byte reaches it. Reset (synchronous, active high) empties the queue and output,
// restarts the frame and sets header_len=5, header_crc_seed=0xff, frame_crc_seed=0xffff.
module frame_header_and_body_crc_checker_core (
   input  logic                               clock,
   input  logic                               reset,
   fhcc_req_if.sink                           req_ch,
   fhcc_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [fhcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fhcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [fhcc_pkg::HLEN_W-1:0]   hlen_ff, hlen_in;
   logic [fhcc_pkg::SEED8_W-1:0]  hseed_ff, hseed_in;
   logic [fhcc_pkg::SEED16_W-1:0] fseed_ff, fseed_in;

   logic               q_push, q_pop, q_full, q_valid;
   fhcc_pkg::item_type q_in_item, q_head;

   always_comb begin
      hlen_in  = hlen_ff;
      hseed_in = hseed_ff;
      fseed_in = fseed_ff;
      if (csr_we) begin
         unique case (csr_index)
            fhcc_pkg::CSR_HEADER_LEN:      hlen_in  = csr_wdata[fhcc_pkg::HLEN_W-1:0];
            fhcc_pkg::CSR_HEADER_CRC_SEED: hseed_in = csr_wdata[fhcc_pkg::SEED8_W-1:0];
            fhcc_pkg::CSR_FRAME_CRC_SEED:  fseed_in = csr_wdata[fhcc_pkg::SEED16_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hlen_ff  <= fhcc_pkg::HEADER_LEN_RST;
         hseed_ff <= fhcc_pkg::HDR_SEED_RST;
         fseed_ff <= fhcc_pkg::FRM_SEED_RST;
      end else begin
         hlen_ff  <= hlen_in;
         hseed_ff <= hseed_in;
         fseed_ff <= fseed_in;
      end
   end

   fhcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .header_len (hlen_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   fhcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   fhcc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_head),
      .q_pop    (q_pop),
      .hdr_seed (hseed_ff),
      .frm_seed (fseed_ff),
      .rsp      (rsp_ch)
   );

endmodule

>>> src/fhcc_checker.sv
// Port-level checks for the frame CRC checker core, attached by bind.
// Depends only on the top level's ports.
module fhcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        header_ok,
   input logic        frame_ok,
   input logic [7:0]  header_crc,
   input logic [15:0] frame_crc
);

   // result held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(header_ok) && $stable(frame_ok)
         && $stable(header_crc) && $stable(frame_crc))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // queue empty after reset, so bytes are taken at once
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind frame_header_and_body_crc_checker_core fhcc_checker u_fhcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .header_ok  (rsp_ch.header_ok),
   .frame_ok   (rsp_ch.frame_ok),
   .header_crc (rsp_ch.header_crc),
   .frame_crc  (rsp_ch.frame_crc)
);
